// File: src/cps_pkg.sv
// shared widths and constants for the closest point on segment pipeline
`default_nettype none
package cps_pkg;
  localparam int CW      = 16;       // coordinate width
  localparam int DW      = 17;       // coordinate difference width
  localparam int LW      = 34;       // squared length width
  localparam int DOTW    = 35;       // dot product width
  localparam int MAGW    = 51;       // offset numerator magnitude width
  localparam int NUMW    = 53;       // rounded numerator width
  localparam int DENW    = 35;       // doubled denominator width
  localparam int QW      = 18;       // quotient width before saturation
  localparam int SUMW    = 20;       // start plus offset width
  localparam int DISTW   = 17;       // distance width
  localparam int D2W     = 35;       // squared distance width
  localparam int SQW     = 35;       // square root working width
  localparam int SQSTEPS = 17;       // result bits of the square root

  localparam int FRONT_LAT = 6;
  localparam int DIV_LAT   = QW + 3;
  localparam int SQRT_LAT  = SQSTEPS + 4;
  localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + SQRT_LAT;

  localparam logic signed [SUMW-1:0] COORD_MAX = SUMW'(32767);
  localparam logic signed [SUMW-1:0] COORD_MIN = -SUMW'(32768);
  localparam logic [DISTW-1:0]       DIST_MAX  = '1;
endpackage
`default_nettype wire

// File: src/cps_front.sv
// front stages: differences, products, optional clamp of the dot product and offset numerators
`default_nettype none
module cps_front (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  wire signed [cps_pkg::CW-1:0] start_x_i,
  input  wire signed [cps_pkg::CW-1:0] start_y_i,
  input  wire signed [cps_pkg::CW-1:0] end_x_i,
  input  wire signed [cps_pkg::CW-1:0] end_y_i,
  input  wire signed [cps_pkg::CW-1:0] query_x_i,
  input  wire signed [cps_pkg::CW-1:0] query_y_i,
  input  wire                          clamp_i,
  output logic [cps_pkg::MAGW-1:0]     mag_x_o,
  output logic [cps_pkg::MAGW-1:0]     mag_y_o,
  output logic                         neg_x_o,
  output logic                         neg_y_o,
  output logic [cps_pkg::LW-1:0]       len2_o,
  output logic                         degen_o,
  output logic signed [cps_pkg::CW-1:0] sx_o,
  output logic signed [cps_pkg::CW-1:0] sy_o,
  output logic signed [cps_pkg::CW-1:0] qx_o,
  output logic signed [cps_pkg::CW-1:0] qy_o
);
  localparam int DW   = cps_pkg::DW;
  localparam int CW   = cps_pkg::CW;
  localparam int LW   = cps_pkg::LW;
  localparam int DOTW = cps_pkg::DOTW;
  localparam int HW   = LW / 2;

  // stage 1
  logic signed [DW-1:0] s1_dx_q, s1_dy_q, s1_px_q, s1_py_q;
  logic signed [CW-1:0] s1_sx_q, s1_sy_q, s1_qx_q, s1_qy_q;
  logic                 s1_clamp_q;
  // stage 2
  logic [LW-2:0]          s2_dxx_q, s2_dyy_q;
  logic signed [LW-1:0]   s2_pxd_q, s2_pyd_q;
  logic signed [DW-1:0]   s2_dx_q, s2_dy_q;
  logic signed [CW-1:0]   s2_sx_q, s2_sy_q, s2_qx_q, s2_qy_q;
  logic                   s2_clamp_q;
  // stage 3
  logic signed [DOTW-1:0] s3_dot_q;
  logic [LW-1:0]          s3_len2_q;
  logic                   s3_degen_q;
  logic signed [DW-1:0]   s3_dx_q, s3_dy_q;
  logic signed [CW-1:0]   s3_sx_q, s3_sy_q, s3_qx_q, s3_qy_q;
  // stage 4
  logic [LW-1:0]          s4_adot_q, s4_len2_q;
  logic [DW-1:0]          s4_adx_q, s4_ady_q;
  logic                   s4_nx_q, s4_ny_q, s4_degen_q;
  logic signed [CW-1:0]   s4_sx_q, s4_sy_q, s4_qx_q, s4_qy_q;
  // stage 5
  logic [DW+HW-1:0]       s5_plx_q, s5_phx_q, s5_ply_q, s5_phy_q;
  logic [LW-1:0]          s5_len2_q;
  logic                   s5_nx_q, s5_ny_q, s5_degen_q;
  logic signed [CW-1:0]   s5_sx_q, s5_sy_q, s5_qx_q, s5_qy_q;

  logic signed [DW-1:0]   dx_d, dy_d, px_d, py_d;
  logic signed [DOTW-1:0] dot_raw, dot_d;
  logic [LW-1:0]          len2_d;
  logic signed [DOTW-1:0] len2_s;
  logic                   dneg;
  logic [cps_pkg::MAGW-1:0] magx_d, magy_d;

  assign dx_d = DW'(end_x_i) - DW'(start_x_i);
  assign dy_d = DW'(end_y_i) - DW'(start_y_i);
  assign px_d = DW'(query_x_i) - DW'(start_x_i);
  assign py_d = DW'(query_y_i) - DW'(start_y_i);

  assign dot_raw = DOTW'(s2_pxd_q) + DOTW'(s2_pyd_q);
  assign len2_d  = LW'(s2_dxx_q) + LW'(s2_dyy_q);
  assign len2_s  = $signed({1'b0, len2_d});

  always_comb begin
    dot_d = dot_raw;
    if (s2_clamp_q) begin
      if (dot_raw < 0) begin
        dot_d = '0;
      end else if (dot_raw > len2_s) begin
        dot_d = len2_s;
      end
    end
  end

  assign dneg   = s3_dot_q[DOTW-1];
  assign magx_d = (cps_pkg::MAGW'(s5_phx_q) << HW) + cps_pkg::MAGW'(s5_plx_q);
  assign magy_d = (cps_pkg::MAGW'(s5_phy_q) << HW) + cps_pkg::MAGW'(s5_ply_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_dx_q    <= dx_d;
      s1_dy_q    <= dy_d;
      s1_px_q    <= px_d;
      s1_py_q    <= py_d;
      s1_sx_q    <= start_x_i;
      s1_sy_q    <= start_y_i;
      s1_qx_q    <= query_x_i;
      s1_qy_q    <= query_y_i;
      s1_clamp_q <= clamp_i;

      s2_dxx_q   <= (LW-1)'(s1_dx_q * s1_dx_q);
      s2_dyy_q   <= (LW-1)'(s1_dy_q * s1_dy_q);
      s2_pxd_q   <= LW'(s1_px_q * s1_dx_q);
      s2_pyd_q   <= LW'(s1_py_q * s1_dy_q);
      s2_dx_q    <= s1_dx_q;
      s2_dy_q    <= s1_dy_q;
      s2_sx_q    <= s1_sx_q;
      s2_sy_q    <= s1_sy_q;
      s2_qx_q    <= s1_qx_q;
      s2_qy_q    <= s1_qy_q;
      s2_clamp_q <= s1_clamp_q;

      s3_dot_q   <= dot_d;
      s3_len2_q  <= len2_d;
      s3_degen_q <= (len2_d == '0);
      s3_dx_q    <= s2_dx_q;
      s3_dy_q    <= s2_dy_q;
      s3_sx_q    <= s2_sx_q;
      s3_sy_q    <= s2_sy_q;
      s3_qx_q    <= s2_qx_q;
      s3_qy_q    <= s2_qy_q;

      s4_adot_q  <= dneg ? LW'(-s3_dot_q) : LW'(s3_dot_q);
      s4_adx_q   <= s3_dx_q[DW-1] ? DW'(-s3_dx_q) : DW'(s3_dx_q);
      s4_ady_q   <= s3_dy_q[DW-1] ? DW'(-s3_dy_q) : DW'(s3_dy_q);
      s4_nx_q    <= s3_dx_q[DW-1] ^ dneg;
      s4_ny_q    <= s3_dy_q[DW-1] ^ dneg;
      s4_len2_q  <= s3_len2_q;
      s4_degen_q <= s3_degen_q;
      s4_sx_q    <= s3_sx_q;
      s4_sy_q    <= s3_sy_q;
      s4_qx_q    <= s3_qx_q;
      s4_qy_q    <= s3_qy_q;

      s5_plx_q   <= s4_adx_q * s4_adot_q[HW-1:0];
      s5_phx_q   <= s4_adx_q * s4_adot_q[LW-1:HW];
      s5_ply_q   <= s4_ady_q * s4_adot_q[HW-1:0];
      s5_phy_q   <= s4_ady_q * s4_adot_q[LW-1:HW];
      s5_len2_q  <= s4_len2_q;
      s5_nx_q    <= s4_nx_q;
      s5_ny_q    <= s4_ny_q;
      s5_degen_q <= s4_degen_q;
      s5_sx_q    <= s4_sx_q;
      s5_sy_q    <= s4_sy_q;
      s5_qx_q    <= s4_qx_q;
      s5_qy_q    <= s4_qy_q;

      // zero-length segment: zero offset over a unit denominator
      mag_x_o    <= s5_degen_q ? '0 : magx_d;
      mag_y_o    <= s5_degen_q ? '0 : magy_d;
      len2_o     <= s5_degen_q ? LW'(1) : s5_len2_q;
      neg_x_o    <= s5_nx_q;
      neg_y_o    <= s5_ny_q;
      degen_o    <= s5_degen_q;
      sx_o       <= s5_sx_q;
      sy_o       <= s5_sy_q;
      qx_o       <= s5_qx_q;
      qy_o       <= s5_qy_q;
    end
  end
endmodule
`default_nettype wire

// File: src/cps_div.sv
// pipelined restoring divider, rounds the offset, adds it to the start coordinate and saturates the sum
`default_nettype none
module cps_div (
  input  wire                           clk_i,
  input  wire                           en_i,
  input  wire [cps_pkg::MAGW-1:0]       mag_i,
  input  wire                           neg_i,
  input  wire [cps_pkg::LW-1:0]         len2_i,
  input  wire signed [cps_pkg::CW-1:0]  start_i,
  output logic signed [cps_pkg::CW-1:0] nearest_o
);
  localparam int NUMW = cps_pkg::NUMW;
  localparam int DENW = cps_pkg::DENW;
  localparam int QW   = cps_pkg::QW;
  localparam int SUMW = cps_pkg::SUMW;
  localparam int CW   = cps_pkg::CW;

  logic [NUMW-1:0]      a_num_q;
  logic [DENW-1:0]      a_den_q;
  logic                 a_neg_q;
  logic signed [CW-1:0] a_st_q;

  logic [NUMW-1:0]      rem_q [QW+1];
  logic [QW-1:0]        quo_q [QW+1];
  logic [DENW-1:0]      den_q [QW+1];
  logic                 ovf_q [QW+1];
  logic                 neg_q [QW+1];
  logic signed [CW-1:0] st_q  [QW+1];

  logic [NUMW-1:0]      shd [QW];
  logic                 take [QW];
  logic [QW-1:0]        q_fin;
  logic signed [SUMW-1:0] sum;

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      shd[k]  = NUMW'(den_q[k]) << (QW - 1 - k);
      take[k] = !ovf_q[k] && (rem_q[k] >= shd[k]);
    end
  end

  assign q_fin = ovf_q[QW] ? '1 : quo_q[QW];
  assign sum   = neg_q[QW] ? SUMW'(st_q[QW]) - $signed(SUMW'(q_fin))
                           : SUMW'(st_q[QW]) + $signed(SUMW'(q_fin));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_num_q  <= (NUMW'(mag_i) << 1) + NUMW'(len2_i);
      a_den_q  <= {len2_i, 1'b0};
      a_neg_q  <= neg_i;
      a_st_q   <= start_i;

      rem_q[0] <= a_num_q;
      quo_q[0] <= '0;
      den_q[0] <= a_den_q;
      ovf_q[0] <= a_num_q >= (NUMW'(a_den_q) << QW);
      neg_q[0] <= a_neg_q;
      st_q[0]  <= a_st_q;

      for (int k = 0; k < QW; k++) begin
        rem_q[k+1] <= take[k] ? rem_q[k] - shd[k] : rem_q[k];
        quo_q[k+1] <= quo_q[k] | (take[k] ? QW'(1) << (QW - 1 - k) : '0);
        den_q[k+1] <= den_q[k];
        ovf_q[k+1] <= ovf_q[k];
        neg_q[k+1] <= neg_q[k];
        st_q[k+1]  <= st_q[k];
      end

      if (sum > cps_pkg::COORD_MAX) begin
        nearest_o <= CW'(cps_pkg::COORD_MAX);
      end else if (sum < cps_pkg::COORD_MIN) begin
        nearest_o <= CW'(cps_pkg::COORD_MIN);
      end else begin
        nearest_o <= CW'(sum);
      end
    end
  end
endmodule
`default_nettype wire

// File: src/cps_sqrt.sv
// distance stages: squared difference sum and pipelined rounded square root
`default_nettype none
module cps_sqrt (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  wire signed [cps_pkg::CW-1:0] qx_i,
  input  wire signed [cps_pkg::CW-1:0] qy_i,
  input  wire signed [cps_pkg::CW-1:0] nx_i,
  input  wire signed [cps_pkg::CW-1:0] ny_i,
  output logic [cps_pkg::DISTW-1:0]    dist_o
);
  localparam int DW  = cps_pkg::DW;
  localparam int D2W = cps_pkg::D2W;
  localparam int SQW = cps_pkg::SQW;
  localparam int NS  = cps_pkg::SQSTEPS;

  logic signed [DW-1:0] rx_q, ry_q;
  logic [2*DW-1:0]      sx_q, sy_q;
  logic [SQW-1:0]       x_q [NS+1];
  logic [SQW-1:0]       r_q [NS+1];

  logic [SQW-1:0] bitv [NS];
  logic [SQW-1:0] trial [NS];
  logic           take [NS];

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      bitv[k]  = SQW'(1) << (2 * (NS - 1 - k));
      trial[k] = r_q[k] + bitv[k];
      take[k]  = x_q[k] >= trial[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q   <= DW'(qx_i) - DW'(nx_i);
      ry_q   <= DW'(qy_i) - DW'(ny_i);
      sx_q   <= (2*DW)'(rx_q * rx_q);
      sy_q   <= (2*DW)'(ry_q * ry_q);
      x_q[0] <= D2W'(sx_q) + D2W'(sy_q);
      r_q[0] <= '0;
      for (int k = 0; k < NS; k++) begin
        x_q[k+1] <= take[k] ? x_q[k] - trial[k] : x_q[k];
        r_q[k+1] <= take[k] ? (r_q[k] >> 1) + bitv[k] : r_q[k] >> 1;
      end
      // round up when the remainder passes the root
      dist_o <= cps_pkg::DISTW'(r_q[NS] + SQW'(x_q[NS] > r_q[NS]));
    end
  end
endmodule
`default_nettype wire

// File: src/closest_point_on_segment.sv
// Closest point on a 2-D segment or line with the distance to it, signed Q12.4 coordinates.
// One transaction enters per cycle while the output is not stalled; the pipeline
// holds the 18-step quotient pipeline of the offset division and the
// 17-step square root pipeline. The whole pipeline advances whenever its last stage
// is empty or being taken, so a stalled output holds every stage in place.
// A zero-length segment returns the start point with degenerate set.
`default_nettype none
module closest_point_on_segment (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire signed [cps_pkg::CW-1:0]  start_x_i,
  input  wire signed [cps_pkg::CW-1:0]  start_y_i,
  input  wire signed [cps_pkg::CW-1:0]  end_x_i,
  input  wire signed [cps_pkg::CW-1:0]  end_y_i,
  input  wire signed [cps_pkg::CW-1:0]  query_x_i,
  input  wire signed [cps_pkg::CW-1:0]  query_y_i,
  input  wire                           clamp_to_segment_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic signed [cps_pkg::CW-1:0] nearest_x_o,
  output logic signed [cps_pkg::CW-1:0] nearest_y_o,
  output logic [cps_pkg::DISTW-1:0]     distance_o,
  output logic                          degenerate_o
);
  localparam int CW  = cps_pkg::CW;
  localparam int LAT = cps_pkg::TOTAL_LAT;
  localparam int DL  = cps_pkg::DIV_LAT;
  localparam int SL  = cps_pkg::SQRT_LAT;

  logic en;
  logic [LAT-1:0] vld_q;

  logic [cps_pkg::MAGW-1:0] mag_x, mag_y;
  logic                     neg_x, neg_y, degen;
  logic [cps_pkg::LW-1:0]   len2;
  logic signed [CW-1:0]     sx, sy, qx, qy, nx, ny;

  logic signed [CW-1:0] qxd_q [DL];
  logic signed [CW-1:0] qyd_q [DL];
  logic signed [CW-1:0] nxd_q [SL];
  logic signed [CW-1:0] nyd_q [SL];
  logic                 dgd_q [DL+SL];

  assign en          = !vld_q[LAT-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  cps_front u_front (
    .clk_i     (clk_i),
    .en_i      (en),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .query_x_i (query_x_i),
    .query_y_i (query_y_i),
    .clamp_i   (clamp_to_segment_i),
    .mag_x_o   (mag_x),
    .mag_y_o   (mag_y),
    .neg_x_o   (neg_x),
    .neg_y_o   (neg_y),
    .len2_o    (len2),
    .degen_o   (degen),
    .sx_o      (sx),
    .sy_o      (sy),
    .qx_o      (qx),
    .qy_o      (qy)
  );

  cps_div u_div_x (
    .clk_i     (clk_i),
    .en_i      (en),
    .mag_i     (mag_x),
    .neg_i     (neg_x),
    .len2_i    (len2),
    .start_i   (sx),
    .nearest_o (nx)
  );

  cps_div u_div_y (
    .clk_i     (clk_i),
    .en_i      (en),
    .mag_i     (mag_y),
    .neg_i     (neg_y),
    .len2_i    (len2),
    .start_i   (sy),
    .nearest_o (ny)
  );

  cps_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .qx_i   (qxd_q[DL-1]),
    .qy_i   (qyd_q[DL-1]),
    .nx_i   (nx),
    .ny_i   (ny),
    .dist_o (distance_o)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      qxd_q[0] <= qx;
      qyd_q[0] <= qy;
      nxd_q[0] <= nx;
      nyd_q[0] <= ny;
      dgd_q[0] <= degen;
      for (int k = 1; k < DL; k++) begin
        qxd_q[k] <= qxd_q[k-1];
        qyd_q[k] <= qyd_q[k-1];
      end
      for (int k = 1; k < SL; k++) begin
        nxd_q[k] <= nxd_q[k-1];
        nyd_q[k] <= nyd_q[k-1];
      end
      for (int k = 1; k < DL + SL; k++) begin
        dgd_q[k] <= dgd_q[k-1];
      end
    end
  end

  assign nearest_x_o  = nxd_q[SL-1];
  assign nearest_y_o  = nyd_q[SL-1];
  assign degenerate_o = dgd_q[DL+SL-1];

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted transaction did not enter the pipeline");

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distance_o <= cps_pkg::DIST_MAX)
    else $error("distance out of range");
endmodule
`default_nettype wire
